/* rtl/moving_average_settling_detector_top_macros.svh */
// Assertion macros for the moving-average settling detector checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef MOVING_AVERAGE_SETTLING_DETECTOR_TOP_MACROS_SVH
`define MOVING_AVERAGE_SETTLING_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/msd_pkg.sv */
// Shared constants, codes and types of the moving-average settling detector.
// No dependencies.
package msd_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 16;
  localparam int AVG_W     = 16;
  localparam int DELTA_W   = 12;
  localparam int LIMIT_W   = 17;
  localparam int COUNT_W   = 18;
  localparam int CFG_W     = 17;
  localparam int REG_IDX_W = 2;

  localparam int WINDOW_DEFAULT = 10;

  // Reciprocal divide: avg = (sum * ceil(2^DIV_SHIFT / WINDOW)) >> DIV_SHIFT
  localparam int DIV_SHIFT = 21;
  localparam int RECIP_W   = 22;

  localparam logic [DELTA_W-1:0] DELTA_RESET = 12'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd99999;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_STABLE_DELTA  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 2'd1;

  typedef struct packed {
    logic upd;
    logic clr;
  } ch_ctrl_t;

  typedef struct packed {
    logic [AVG_W-1:0] avg;
    logic             stable;
  } ch_res_t;

  typedef struct packed {
    logic               done;
    logic               succ;
    logic [COUNT_W-1:0] count;
  } status_t;

endpackage

/* rtl/msd_if.sv */
// Request and result channel interfaces of the settling detector.
// Depends on msd_pkg.
interface msd_item_if import msd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [SAMPLE_W-1:0] sample_nh3;
  logic [SAMPLE_W-1:0] sample_co;
  logic [SAMPLE_W-1:0] sample_no2;

  modport source (output valid, op, sample_nh3, sample_co, sample_no2, input ready);
  modport sink (input valid, op, sample_nh3, sample_co, sample_no2, output ready);
endinterface

interface msd_result_if import msd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [AVG_W-1:0]   avg_nh3;
  logic [AVG_W-1:0]   avg_co;
  logic [AVG_W-1:0]   avg_no2;
  logic               stable_nh3;
  logic               stable_co;
  logic               stable_no2;
  logic               finished;
  logic               succeeded;
  logic [COUNT_W-1:0] attempts;

  modport source (output valid, avg_nh3, avg_co, avg_no2, stable_nh3, stable_co,
                  stable_no2, finished, succeeded, attempts, input ready);
  modport sink (input valid, avg_nh3, avg_co, avg_no2, stable_nh3, stable_co,
                stable_no2, finished, succeeded, attempts, output ready);
endinterface

/* rtl/msd_channel.sv */
// One sensor channel: sample ring, running sum, floored average and stability test.
// Depends on msd_pkg.
module msd_channel import msd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  ch_ctrl_t            ctrl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [DELTA_W-1:0]  delta,
  output ch_res_t             res
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SAMPLE_W-1:0] ring [WINDOW];
  logic [PTR_W-1:0]    ptr;
  logic [SUM_W-1:0]    sum;
  logic                stab;

  logic [SAMPLE_W-1:0]      old;
  logic [SUM_W-1:0]         sum_next;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [AVG_W-1:0]         avg;
  logic [AVG_W-1:0]         cur;
  logic [AVG_W-1:0]         diff;
  logic                     hit;
  logic                     stab_next;

  assign old = ring[ptr];

  always_comb begin
    if (ctrl.clr) begin
      sum_next = '0;
    end else if (ctrl.upd) begin
      sum_next = sum + SUM_W'(sample) - SUM_W'(old);
    end else begin
      sum_next = sum;
    end
  end

  assign prod = (SUM_W+RECIP_W)'(sum_next) * (SUM_W+RECIP_W)'(RECIP);
  assign avg  = prod[DIV_SHIFT +: AVG_W];
  assign cur  = AVG_W'(sample);
  assign diff = (avg >= cur) ? (avg - cur) : (cur - avg);
  assign hit  = diff < AVG_W'(delta);

  always_comb begin
    if (ctrl.clr) begin
      stab_next = 1'b0;
    end else if (ctrl.upd) begin
      stab_next = hit;
    end else begin
      stab_next = stab;
    end
  end

  assign res.avg    = avg;
  assign res.stable = stab_next;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      ptr  <= '0;
      sum  <= '0;
      stab <= 1'b0;
    end else if (ctrl.upd) begin
      ring[ptr] <= sample;
      ptr       <= (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
      sum       <= sum_next;
      stab      <= stab_next;
    end
  end

endmodule

/* rtl/msd_ctrl.sv */
// Run control: attempt counter, finished and success flags.
// Depends on msd_pkg.
module msd_ctrl import msd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic               op,
  input  logic               any,
  input  logic [LIMIT_W-1:0] limit,
  output status_t            cur,
  output status_t            nxt
);

  logic below;

  assign below = cur.count < COUNT_W'(limit);

  always_comb begin
    nxt = cur;
    if (go) begin
      if (op == OP_RESTART) begin
        nxt = '0;
      end else if (!cur.done) begin
        if (any) begin
          nxt.done = 1'b1;
          nxt.succ = below;
        end else begin
          nxt.count = cur.count + 1'b1;
          if (!below) begin
            nxt.done = 1'b1;
            nxt.succ = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else begin
      cur <= nxt;
    end
  end

endmodule

/* rtl/moving_average_settling_detector_top.sv */
// Top level of the three-channel moving-average settling detector.
// Depends on msd_pkg, msd_if, msd_channel and msd_ctrl.
//
//   channel  dir  handshake       payload
//   item     in   valid / ready   op, sample_nh3, sample_co, sample_no2
//   result   out  valid / ready   avg_*, stable_*, finished, succeeded, attempts
//   wr       in   wr_en           wr_index, wr_data
//
// One request per cycle sustained while the result side is ready; each
// passes the input register, then the result register, to a valid result.
// The running-sum update, reciprocal divide and stability compare fit between
// the two registers, so state is updated in time for the next request.
// A stalled result holds; a new request is still taken while the input
// register is empty. Synchronous reset clears run state and both valid bits.
module moving_average_settling_detector_top import msd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  msd_item_if.sink             item,
  msd_result_if.source         result,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  logic [DELTA_W-1:0] stable_delta;
  logic [LIMIT_W-1:0] attempt_limit;

  logic                s1_vld;
  logic                s1_op;
  logic [SAMPLE_W-1:0] s1_nh3;
  logic [SAMPLE_W-1:0] s1_co;
  logic [SAMPLE_W-1:0] s1_no2;
  logic                s1_go;

  logic               o_vld;
  logic [AVG_W-1:0]   o_avg_nh3;
  logic [AVG_W-1:0]   o_avg_co;
  logic [AVG_W-1:0]   o_avg_no2;
  logic               o_stab_nh3;
  logic               o_stab_co;
  logic               o_stab_no2;
  status_t            o_status;

  ch_ctrl_t ch_ctrl;
  ch_res_t  res_nh3;
  ch_res_t  res_co;
  ch_res_t  res_no2;
  status_t  st_cur;
  status_t  st_nxt;
  logic     any;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_delta  <= DELTA_RESET;
      attempt_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STABLE_DELTA:  stable_delta  <= wr_data[DELTA_W-1:0];
        REG_ATTEMPT_LIMIT: attempt_limit <= wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go      = s1_vld && (!o_vld || result.ready);
  assign item.ready = !rst && (!s1_vld || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (item.ready) begin
      s1_vld <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op  <= item.op;
      s1_nh3 <= item.sample_nh3;
      s1_co  <= item.sample_co;
      s1_no2 <= item.sample_no2;
    end
  end

  assign ch_ctrl.clr = s1_go && (s1_op == OP_RESTART);
  assign ch_ctrl.upd = s1_go && (s1_op == OP_SAMPLE) && !st_cur.done;

  msd_channel #(.WINDOW(WINDOW)) u_ch_nh3 (
    .clk(clk), .rst(rst), .ctrl(ch_ctrl), .sample(s1_nh3),
    .delta(stable_delta), .res(res_nh3)
  );

  msd_channel #(.WINDOW(WINDOW)) u_ch_co (
    .clk(clk), .rst(rst), .ctrl(ch_ctrl), .sample(s1_co),
    .delta(stable_delta), .res(res_co)
  );

  msd_channel #(.WINDOW(WINDOW)) u_ch_no2 (
    .clk(clk), .rst(rst), .ctrl(ch_ctrl), .sample(s1_no2),
    .delta(stable_delta), .res(res_no2)
  );

  assign any = res_nh3.stable || res_co.stable || res_no2.stable;

  msd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .go(s1_go), .op(s1_op), .any(any),
    .limit(attempt_limit), .cur(st_cur), .nxt(st_nxt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (s1_go) begin
      o_vld <= 1'b1;
    end else if (result.ready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      o_avg_nh3  <= res_nh3.avg;
      o_avg_co   <= res_co.avg;
      o_avg_no2  <= res_no2.avg;
      o_stab_nh3 <= res_nh3.stable;
      o_stab_co  <= res_co.stable;
      o_stab_no2 <= res_no2.stable;
      o_status   <= st_nxt;
    end
  end

  assign result.valid      = o_vld;
  assign result.avg_nh3    = o_avg_nh3;
  assign result.avg_co     = o_avg_co;
  assign result.avg_no2    = o_avg_no2;
  assign result.stable_nh3 = o_stab_nh3;
  assign result.stable_co  = o_stab_co;
  assign result.stable_no2 = o_stab_no2;
  assign result.finished   = o_status.done;
  assign result.succeeded  = o_status.succ;
  assign result.attempts   = o_status.count;

endmodule

/* rtl/msd_checker.sv */
// Port-level checks of the settling detector, bound to the top level.
// Depends on msd_pkg and moving_average_settling_detector_top_macros.svh.
`include "moving_average_settling_detector_top_macros.svh"

module msd_checker import msd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic stable_nh3,
  input logic stable_co,
  input logic stable_no2,
  input logic finished,
  input logic succeeded
);

  logic any_stable;

  assign any_stable = stable_nh3 || stable_co || stable_no2;

  `MSD_ASSERT_NOW(a_stable_ends_run, out_valid && any_stable, finished, "stable on open run")
  `MSD_ASSERT_NOW(a_success_stable, out_valid && succeeded, any_stable, "no stable channel")
  `MSD_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid, "stalled result dropped")

endmodule

bind moving_average_settling_detector_top msd_checker u_msd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .stable_nh3(result.stable_nh3),
  .stable_co(result.stable_co),
  .stable_no2(result.stable_no2),
  .finished(result.finished),
  .succeeded(result.succeeded)
);

/* verif/tb_top.sv */
// Self-checking testbench of the moving-average settling detector: a directed
// table, then randomized settle/noise runs under several register settings.
// Depends on msd_pkg, msd_if and moving_average_settling_detector_top.
module tb_top;
  import msd_pkg::*;

  localparam int WIN = WINDOW_DEFAULT;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_ITEMS = 900;
  localparam int PHASES = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] nh3, co, no2;
  } request_t;

  typedef struct packed {
    logic [AVG_W-1:0]   avg_nh3, avg_co, avg_no2;
    logic               stable_nh3, stable_co, stable_no2;
    logic               finished, succeeded;
    logic [COUNT_W-1:0] attempts;
  } reading_t;

  typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_e;

  typedef struct {
    step_kind_e           kind;
    request_t             rq;
    bit                   has_gold;
    reading_t             gold;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
  } step_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  msd_item_if   item_ch ();
  msd_result_if result_ch ();

  moving_average_settling_detector_top dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  logic [SAMPLE_W-1:0] ring_q [3][WIN];
  logic [SUM_W-1:0]    sum_q [3];
  int                  slot;
  logic [COUNT_W-1:0]  tries;
  bit                  done_q, won_q;
  bit                  steady_q [3];
  logic [DELTA_W-1:0]  delta_q;
  logic [LIMIT_W-1:0]  limit_q;

  reading_t awaited [$];
  int       faults = 0;
  int       worked_items = 0;
  int       hold_asks = 0;
  bit       calm = 1'b0;

  function automatic void clear_run();
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < WIN; k++) ring_q[c][k] = '0;
      sum_q[c] = '0;
      steady_q[c] = 1'b0;
    end
    slot = 0;
    tries = '0;
    done_q = 1'b0;
    won_q = 1'b0;
  endfunction

  function automatic reading_t current_reading();
    reading_t r;
    r.avg_nh3 = AVG_W'(sum_q[0] / WIN);
    r.avg_co = AVG_W'(sum_q[1] / WIN);
    r.avg_no2 = AVG_W'(sum_q[2] / WIN);
    r.stable_nh3 = steady_q[0];
    r.stable_co = steady_q[1];
    r.stable_no2 = steady_q[2];
    r.finished = done_q;
    r.succeeded = won_q;
    r.attempts = tries;
    return r;
  endfunction

  function automatic reading_t settle_step(request_t rq);
    logic [SAMPLE_W-1:0] cur [3];
    logic [SAMPLE_W-1:0] old;
    int avg, diff;
    bit any, below;
    cur[0] = rq.nh3;
    cur[1] = rq.co;
    cur[2] = rq.no2;
    any = 1'b0;
    if (rq.op == OP_RESTART) begin
      clear_run();
    end else if (!done_q) begin
      for (int c = 0; c < 3; c++) begin
        old = ring_q[c][slot];
        sum_q[c] = sum_q[c] + SUM_W'(cur[c]) - SUM_W'(old);
        ring_q[c][slot] = cur[c];
        avg = int'(sum_q[c] / WIN);
        diff = (avg >= int'(cur[c])) ? avg - int'(cur[c]) : int'(cur[c]) - avg;
        steady_q[c] = diff < int'(delta_q);
        any |= steady_q[c];
      end
      slot = (slot + 1) % WIN;
      if (any) begin
        done_q = 1'b1;
        won_q = tries < COUNT_W'(limit_q);
      end else begin
        below = tries < COUNT_W'(limit_q);
        tries = tries + 1'b1;
        if (!below) begin
          done_q = 1'b1;
          won_q = 1'b0;
        end
      end
    end
    return current_reading();
  endfunction

  function automatic reading_t golden(int avg, bit st, bit fin, bit ok, int att);
    reading_t r;
    r.avg_nh3 = AVG_W'(avg);
    r.avg_co = AVG_W'(avg);
    r.avg_no2 = AVG_W'(avg);
    r.stable_nh3 = st;
    r.stable_co = st;
    r.stable_no2 = st;
    r.finished = fin;
    r.succeeded = ok;
    r.attempts = COUNT_W'(att);
    return r;
  endfunction

  function automatic step_t item_row(logic op, int a, int b, int c);
    step_t s;
    s.kind = STEP_ITEM;
    s.rq.op = op;
    s.rq.nh3 = SAMPLE_W'(a);
    s.rq.co = SAMPLE_W'(b);
    s.rq.no2 = SAMPLE_W'(c);
    s.has_gold = 1'b0;
    s.gold = '0;
    s.idx = REG_STABLE_DELTA;
    s.val = '0;
    return s;
  endfunction

  function automatic step_t gold_row(logic op, int a, int b, int c, reading_t g);
    step_t s;
    s = item_row(op, a, b, c);
    s.has_gold = 1'b1;
    s.gold = g;
    return s;
  endfunction

  function automatic step_t write_row(logic [REG_IDX_W-1:0] idx, int val);
    step_t s;
    s = item_row(OP_SAMPLE, 0, 0, 0);
    s.kind = STEP_WRITE;
    s.idx = idx;
    s.val = CFG_W'(val);
    return s;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(bit smooth, int lvl, int spread);
    int v;
    if (!smooth) begin
      if ($urandom_range(4, 0) == 0) return $urandom_range(1, 0) ? {SAMPLE_W{1'b1}} : '0;
      return SAMPLE_W'($urandom);
    end
    v = lvl + int'($urandom_range(2 * spread, 0)) - spread;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  function automatic string show(reading_t r);
    return $sformatf("avg %0d/%0d/%0d stable %b%b%b fin %b ok %b att %0d",
                     r.avg_nh3, r.avg_co, r.avg_no2, r.stable_nh3, r.stable_co,
                     r.stable_no2, r.finished, r.succeeded, r.attempts);
  endfunction

  task automatic offer(input request_t rq, input bit use_gold, input reading_t gold);
    int gap;
    reading_t want;
    gap = 0;
    if (!calm) while ($urandom_range(99, 0) < 18) gap++;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= rq.op;
    item_ch.sample_nh3 <= rq.nh3;
    item_ch.sample_co <= rq.co;
    item_ch.sample_no2 <= rq.no2;
    do @(posedge clk); while (!item_ch.ready);
    worked_items++;
    want = settle_step(rq);
    awaited.push_back(use_gold ? gold : want);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    item_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_STABLE_DELTA) delta_q = val[DELTA_W-1:0];
    else if (idx == REG_ATTEMPT_LIMIT) limit_q = val[LIMIT_W-1:0];
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : drain
    reading_t got, want;
    int hold_left, holds_taken;
    bit bad;
    hold_left = 0;
    holds_taken = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_ch.valid && result_ch.ready) begin
          got.avg_nh3 = result_ch.avg_nh3;
          got.avg_co = result_ch.avg_co;
          got.avg_no2 = result_ch.avg_no2;
          got.stable_nh3 = result_ch.stable_nh3;
          got.stable_co = result_ch.stable_co;
          got.stable_no2 = result_ch.stable_no2;
          got.finished = result_ch.finished;
          got.succeeded = result_ch.succeeded;
          got.attempts = result_ch.attempts;
          if (awaited.size() == 0) begin
            if (faults < 10) $display("%0t unexpected result: %s", $time, show(got));
            faults++;
          end else begin
            want = awaited.pop_front();
            bad = (got.avg_nh3 !== want.avg_nh3) || (got.avg_co !== want.avg_co) ||
                  (got.avg_no2 !== want.avg_no2) || (got.stable_nh3 !== want.stable_nh3) ||
                  (got.stable_co !== want.stable_co) || (got.stable_no2 !== want.stable_no2) ||
                  (got.finished !== want.finished) || (got.succeeded !== want.succeeded) ||
                  (got.attempts !== want.attempts);
            if (bad) begin
              if (faults < 10)
                $display("%0t result mismatch: expected %s, got %s", $time, show(want),
                         show(got));
              faults++;
            end
          end
        end
        if (hold_left > 0) begin
          result_ch.ready <= 1'b0;
          hold_left--;
        end else if (holds_taken != hold_asks) begin
          holds_taken++;
          hold_left = 63;
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= calm || ($urandom_range(99, 0) >= 18);
        end
      end
    end
  end

  initial begin : stim
    step_t    plan [$];
    reading_t cleared;
    request_t rq;
    int       quota, len, spread, extra;
    int       lvl [3];
    bit       smooth;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_STABLE_DELTA;
    wr_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.op <= OP_SAMPLE;
    item_ch.sample_nh3 <= '0;
    item_ch.sample_co <= '0;
    item_ch.sample_no2 <= '0;
    delta_q = DELTA_RESET;
    limit_q = LIMIT_RESET;
    clear_run();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    cleared = golden(0, 0, 0, 0, 0);
    plan.push_back(gold_row(OP_RESTART, 4095, 4095, 4095, cleared));
    plan.push_back(gold_row(OP_SAMPLE, 0, 0, 0, golden(0, 1, 1, 1, 0)));
    plan.push_back(gold_row(OP_SAMPLE, 4095, 4095, 4095, golden(0, 1, 1, 1, 0)));
    plan.push_back(write_row(REG_STABLE_DELTA, 0));
    plan.push_back(gold_row(OP_SAMPLE, 123, 456, 789, golden(0, 1, 1, 1, 0)));
    plan.push_back(gold_row(OP_RESTART, 0, 0, 0, cleared));
    plan.push_back(gold_row(OP_SAMPLE, 4095, 4095, 4095, golden(409, 0, 0, 0, 1)));
    plan.push_back(item_row(OP_SAMPLE, 4095, 0, 2048));
    plan.push_back(item_row(OP_SAMPLE, 1, 4094, 2047));
    plan.push_back(write_row(REG_ATTEMPT_LIMIT, 4));
    plan.push_back(item_row(OP_SAMPLE, 2048, 1, 4094));
    plan.push_back(item_row(OP_SAMPLE, 0, 4095, 0));
    plan.push_back(item_row(OP_SAMPLE, 5, 5, 5));
    plan.push_back(write_row(REG_ATTEMPT_LIMIT, 0));
    plan.push_back(write_row(REG_STABLE_DELTA, 4095));
    plan.push_back(gold_row(OP_RESTART, 1, 2, 3, cleared));
    plan.push_back(gold_row(OP_SAMPLE, 0, 0, 0, golden(0, 1, 1, 0, 0)));
    plan.push_back(write_row(REG_STABLE_DELTA, 0));
    plan.push_back(gold_row(OP_RESTART, 0, 0, 0, cleared));
    plan.push_back(gold_row(OP_SAMPLE, 4095, 4095, 4095, golden(409, 0, 1, 0, 1)));
    plan.push_back(write_row(REG_ATTEMPT_LIMIT, 131071));
    plan.push_back(write_row(REG_STABLE_DELTA, 2));
    plan.push_back(write_row(REG_SPARE_A, 0));
    plan.push_back(write_row(REG_SPARE_B, 0));
    plan.push_back(gold_row(OP_RESTART, 0, 0, 0, cleared));
    plan.push_back(gold_row(OP_SAMPLE, 0, 0, 0, golden(0, 1, 1, 1, 0)));
    plan.push_back(gold_row(OP_RESTART, 4095, 0, 4095, cleared));
    plan.push_back(item_row(OP_SAMPLE, 2730, 1365, 4095));
    plan.push_back(item_row(OP_SAMPLE, 1365, 2730, 0));
    plan.push_back(item_row(OP_SAMPLE, 4095, 4095, 4095));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) write_reg(plan[i].idx, plan[i].val);
      else offer(plan[i].rq, plan[i].has_gold, plan[i].gold);
    end

    worked_items = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_STABLE_DELTA, CFG_W'(DELTA_RESET));
          write_reg(REG_ATTEMPT_LIMIT, CFG_W'(LIMIT_RESET));
        end
        1: begin
          write_reg(REG_STABLE_DELTA, '0);
          write_reg(REG_ATTEMPT_LIMIT, CFG_W'($urandom_range(12, 3)));
        end
        2: begin
          write_reg(REG_STABLE_DELTA, CFG_W'(SAMPLE_MAX));
          write_reg(REG_ATTEMPT_LIMIT, '0);
        end
        3: begin
          write_reg(REG_STABLE_DELTA, CFG_W'($urandom_range(6, 1)));
          write_reg(REG_ATTEMPT_LIMIT, CFG_W'($urandom_range(25, 0)));
        end
        4: begin
          write_reg(REG_STABLE_DELTA, CFG_W'(1));
          write_reg(REG_ATTEMPT_LIMIT, {CFG_W{1'b1}});
        end
        5: begin
          write_reg(REG_STABLE_DELTA, CFG_W'($urandom_range(4095, 0)));
          write_reg(REG_ATTEMPT_LIMIT, CFG_W'($urandom_range(131071, 0)));
        end
        6: begin
          write_reg(REG_STABLE_DELTA, CFG_W'($urandom_range(40, 2)));
          write_reg(REG_ATTEMPT_LIMIT, CFG_W'($urandom_range(40, 5)));
        end
        default: begin
          write_reg(REG_STABLE_DELTA, CFG_W'(SAMPLE_MAX));
          write_reg(REG_ATTEMPT_LIMIT, {CFG_W{1'b1}});
        end
      endcase
      calm = (ph == 2);
      if (ph == 1 || ph == 4) hold_asks++;
      quota = (ph + 1) * RANDOM_ITEMS / PHASES;
      while (worked_items < quota) begin
        smooth = ($urandom_range(99, 0) < 75);
        spread = $urandom_range(6, 0);
        len = $urandom_range(24, 1);
        extra = $urandom_range(2, 0);
        for (int c = 0; c < 3; c++)
          lvl[c] = ($urandom_range(9, 0) == 0) ? ($urandom_range(1, 0) ? SAMPLE_MAX : 0)
                                               : int'($urandom_range(SAMPLE_MAX, 0));
        if ($urandom_range(99, 0) < 85) begin
          rq.op = OP_RESTART;
          rq.nh3 = SAMPLE_W'($urandom);
          rq.co = SAMPLE_W'($urandom);
          rq.no2 = SAMPLE_W'($urandom);
          offer(rq, 1'b0, '0);
        end
        for (int k = 0; k < len && extra >= 0; k++) begin
          rq.op = OP_SAMPLE;
          rq.nh3 = draw_sample(smooth, lvl[0], spread);
          rq.co = draw_sample(smooth, lvl[1], spread);
          rq.no2 = draw_sample(smooth, lvl[2], spread);
          offer(rq, 1'b0, '0);
          if (done_q) extra--;
        end
      end
    end

    calm = 1'b0;
    item_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (faults == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
